FILE: rtl/plrf_pkg.sv
package plrf_pkg;

    localparam int DIMENSIONS = 3;
    localparam int COUNT_BITS = 16;
    localparam int MAX_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int CNT_W      = 16;
    localparam logic [CNT_W-1:0] COUNT_LIMIT =
        (COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic OP_TARGET   = 1'b0;
    localparam logic OP_NEIGHBOR = 1'b1;

    localparam logic signed [48:0] FORCE_MAX = 49'sd549755813887;
    localparam logic signed [48:0] FORCE_MIN = -49'sd549755813888;

    localparam logic [4:0] ROOT_STEPS_LAST = 5'd31;
    localparam logic [4:0] DIV_STEPS_LAST  = 5'd30;

    typedef struct packed {
        logic capture;
        logic load_target;
        logic decode;
        logic sq_mul;
        logic sq_add;
        logic root_init;
        logic root_step;
        logic root_chk;
        logic gap_mul;
        logic div_init;
        logic div_step;
        logic t_mul;
        logic acc;
        logic count;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic last;
        logic skip;
        logic chk_skip;
        logic axis_last;
        logic root_last;
        logic div_last;
    } sts_t;

endpackage

FILE: rtl/plrf_ctrl.sv
module plrf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  plrf_pkg::sts_t sts,
    output plrf_pkg::cmd_t cmd
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECODE    = 14'b00000000000010,
        S_SQ_MUL    = 14'b00000000000100,
        S_SQ_ADD    = 14'b00000000001000,
        S_ROOT_INIT = 14'b00000000010000,
        S_ROOT      = 14'b00000000100000,
        S_RCHK      = 14'b00000001000000,
        S_GAP_MUL   = 14'b00000010000000,
        S_DIV_INIT  = 14'b00000100000000,
        S_DIV       = 14'b00001000000000,
        S_T_MUL     = 14'b00010000000000,
        S_ACC       = 14'b00100000000000,
        S_COUNT     = 14'b01000000000000,
        S_FIN       = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.op == plrf_pkg::OP_TARGET) begin
                    cmd.load_target = 1'b1;
                    state_next      = S_FIN;
                end else begin
                    cmd.decode = 1'b1;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL: begin
                if (sts.skip) begin
                    state_next = S_FIN;
                end else begin
                    cmd.sq_mul = 1'b1;
                    state_next = S_SQ_ADD;
                end
            end
            S_SQ_ADD: begin
                cmd.sq_add = 1'b1;
                state_next = sts.axis_last ? S_ROOT_INIT : S_SQ_MUL;
            end
            S_ROOT_INIT: begin
                cmd.root_init = 1'b1;
                state_next    = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (sts.root_last) state_next = S_RCHK;
            end
            S_RCHK: begin
                cmd.root_chk = 1'b1;
                state_next   = sts.chk_skip ? S_FIN : S_GAP_MUL;
            end
            S_GAP_MUL: begin
                cmd.gap_mul = 1'b1;
                state_next  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_T_MUL;
            end
            S_T_MUL: begin
                cmd.t_mul  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = sts.axis_last ? S_COUNT : S_GAP_MUL;
            end
            S_COUNT: begin
                cmd.count  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!sts.last) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register must be free when a new result lands
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");

    // square root runs exactly 32 steps
    a_root_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == S_ROOT) |-> ##31 (state_reg == S_ROOT) ##1 (state_reg == S_RCHK))
        else $error("root step count wrong");

    // a target item without last returns to idle quickly
    a_target_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE && sts.op == plrf_pkg::OP_TARGET && !sts.last) |=>
        (state_reg == S_FIN) ##1 (state_reg == S_IDLE))
        else $error("target load path wrong");

endmodule

FILE: rtl/plrf_dp.sv
module plrf_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  plrf_pkg::cmd_t      cmd,
    output plrf_pkg::sts_t      sts,
    input  logic                cfg_wr,
    input  logic [31:0]         cfg_data,
    input  logic                s_op,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic [30:0]         s_cutoff_radius,
    input  logic                s_tag_valid,
    input  logic [15:0]         s_unit_tag,
    input  logic                s_last,
    output logic signed [39:0]  m_force_x,
    output logic signed [39:0]  m_force_y,
    output logic signed [39:0]  m_force_z,
    output logic [15:0]         m_neighbor_count,
    output logic                m_saturated
);

    localparam int NA = plrf_pkg::MAX_AXES;
    localparam int AXIS_W_L = plrf_pkg::AXIS_W;

    logic [31:0]        gain_reg;
    logic signed [31:0] tgt_pos_reg [NA];
    logic [30:0]        tgt_rad_reg;
    logic               tgt_tv_reg;
    logic [15:0]        tgt_tag_reg;

    logic               in_op_reg, in_last_reg, in_tv_reg;
    logic signed [31:0] in_pos_reg [NA];
    logic [30:0]        in_rad_reg;
    logic [15:0]        in_tag_reg;

    logic [30:0]        mag_reg [NA];
    logic               neg_reg [NA];
    logic               skip_reg;
    logic [AXIS_W_L-1:0] axis_reg;
    logic [4:0]         step_reg;

    logic [63:0]        sumsq_reg, prod_reg;
    logic [63:0]        root_v_reg;
    logic [33:0]        root_rem_reg;
    logic [31:0]        root_reg;
    logic [30:0]        gap_reg, drem_reg, dq_reg;

    logic signed [39:0] acc_reg [NA];
    logic [15:0]        cnt_reg;
    logic               sat_reg;

    logic signed [39:0] out_f_reg [NA];
    logic [15:0]        out_cnt_reg;
    logic               out_sat_reg;

    // decode: differences and magnitudes
    logic signed [32:0] diff   [NA];
    logic [32:0]        mag_w  [NA];
    logic               far_any, tag_hit;

    always_comb begin
        far_any = 1'b0;
        for (int a = 0; a < NA; a++) begin
            diff[a]  = $signed({tgt_pos_reg[a][31], tgt_pos_reg[a]})
                     - $signed({in_pos_reg[a][31], in_pos_reg[a]});
            mag_w[a] = diff[a][32] ? 33'(-diff[a]) : 33'(diff[a]);
            if (a >= plrf_pkg::DIMENSIONS) mag_w[a] = '0;
            if (mag_w[a] > {2'b00, tgt_rad_reg}) far_any = 1'b1;
        end
        tag_hit = tgt_tv_reg && in_tv_reg && (tgt_tag_reg == in_tag_reg);
    end

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_mul) begin
            mul_a = {1'b0, mag_reg[axis_reg]};
            mul_b = {1'b0, mag_reg[axis_reg]};
        end else if (cmd.gap_mul) begin
            mul_a = {1'b0, gap_reg};
            mul_b = {1'b0, mag_reg[axis_reg]};
        end else if (cmd.t_mul) begin
            mul_a = gain_reg;
            mul_b = {1'b0, dq_reg};
        end
    end

    // square root, one result bit a step
    logic [35:0] root_tmp, root_trial;
    logic        root_ge;
    assign root_tmp   = {root_rem_reg, root_v_reg[63:62]};
    assign root_trial = {2'b00, root_reg, 2'b01};
    assign root_ge    = (root_tmp >= root_trial);

    // restoring divide, one quotient bit a step
    logic [31:0] div_tmp, div_sub;
    logic        div_ge;
    assign div_tmp = {drem_reg, dq_reg[30]};
    assign div_ge  = (div_tmp >= root_reg);
    assign div_sub = div_tmp - root_reg;

    logic chk_skip;
    assign chk_skip = (sumsq_reg == 64'd0) || (root_reg > {1'b0, tgt_rad_reg})
                   || ((root_reg == {1'b0, tgt_rad_reg}) && (root_rem_reg != 34'd0));

    // accumulate with clamp
    logic signed [48:0] acc_sum, acc_clamped;
    logic               acc_clip;
    always_comb begin
        acc_sum = neg_reg[axis_reg]
                ? 49'(acc_reg[axis_reg]) - $signed({2'b00, prod_reg[62:16]})
                : 49'(acc_reg[axis_reg]) + $signed({2'b00, prod_reg[62:16]});
        acc_clamped = acc_sum;
        acc_clip    = 1'b0;
        if (acc_sum > plrf_pkg::FORCE_MAX) begin
            acc_clamped = plrf_pkg::FORCE_MAX;
            acc_clip    = 1'b1;
        end else if (acc_sum < plrf_pkg::FORCE_MIN) begin
            acc_clamped = plrf_pkg::FORCE_MIN;
            acc_clip    = 1'b1;
        end
    end

    assign sts.op        = in_op_reg;
    assign sts.last      = in_last_reg;
    assign sts.skip      = skip_reg;
    assign sts.chk_skip  = chk_skip;
    assign sts.axis_last = (axis_reg == AXIS_W_L'(plrf_pkg::DIMENSIONS - 1));
    assign sts.root_last = (step_reg == plrf_pkg::ROOT_STEPS_LAST);
    assign sts.div_last  = (step_reg == plrf_pkg::DIV_STEPS_LAST);

    // payload and working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture) begin
            in_op_reg     <= s_op;
            in_last_reg   <= s_last;
            in_tv_reg     <= s_tag_valid;
            in_tag_reg    <= s_unit_tag;
            in_rad_reg    <= s_cutoff_radius;
            in_pos_reg[0] <= s_pos_x;
            in_pos_reg[1] <= s_pos_y;
            in_pos_reg[2] <= s_pos_z;
        end
        if (cmd.decode) begin
            for (int a = 0; a < NA; a++) begin
                mag_reg[a] <= mag_w[a][30:0];
                neg_reg[a] <= diff[a][32];
            end
            skip_reg  <= tag_hit || far_any;
            sumsq_reg <= '0;
        end
        if (cmd.sq_add) sumsq_reg <= sumsq_reg + prod_reg;
        if (cmd.root_init) begin
            root_v_reg   <= sumsq_reg;
            root_rem_reg <= '0;
            root_reg     <= '0;
        end
        if (cmd.root_step) begin
            root_v_reg <= {root_v_reg[61:0], 2'b00};
            if (root_ge) begin
                root_rem_reg <= 34'(root_tmp - root_trial);
                root_reg     <= {root_reg[30:0], 1'b1};
            end else begin
                root_rem_reg <= root_tmp[33:0];
                root_reg     <= {root_reg[30:0], 1'b0};
            end
        end
        if (cmd.root_chk) gap_reg <= tgt_rad_reg - root_reg[30:0];
        if (cmd.div_init) begin
            drem_reg <= prod_reg[61:31];
            dq_reg   <= prod_reg[30:0];
        end
        if (cmd.div_step) begin
            drem_reg <= div_ge ? div_sub[30:0] : div_tmp[30:0];
            dq_reg   <= {dq_reg[29:0], div_ge};
        end
        if (cmd.emit) begin
            for (int a = 0; a < NA; a++)
                out_f_reg[a] <= (a < plrf_pkg::DIMENSIONS) ? acc_reg[a] : 40'sd0;
            out_cnt_reg <= cnt_reg;
            out_sat_reg <= sat_reg;
        end
    end

    // architectural state, set by reset (gain to 1.0, the rest cleared)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= 32'd65536;
            tgt_rad_reg <= '0;
            tgt_tv_reg  <= 1'b0;
            tgt_tag_reg <= '0;
            cnt_reg     <= '0;
            sat_reg     <= 1'b0;
            axis_reg    <= '0;
            step_reg    <= '0;
            for (int a = 0; a < NA; a++) begin
                tgt_pos_reg[a] <= '0;
                acc_reg[a]     <= '0;
            end
        end else begin
            if (cfg_wr) gain_reg <= cfg_data;
            if (cmd.load_target) begin
                tgt_rad_reg <= in_rad_reg;
                tgt_tv_reg  <= in_tv_reg;
                tgt_tag_reg <= in_tag_reg;
                cnt_reg     <= '0;
                sat_reg     <= 1'b0;
                for (int a = 0; a < NA; a++) begin
                    tgt_pos_reg[a] <= in_pos_reg[a];
                    acc_reg[a]     <= '0;
                end
            end
            if (cmd.decode || cmd.root_chk) axis_reg <= '0;
            if (cmd.sq_add && !sts.axis_last) axis_reg <= axis_reg + 1'b1;
            if (cmd.acc) begin
                acc_reg[axis_reg] <= acc_clamped[39:0];
                if (acc_clip) sat_reg <= 1'b1;
                if (!sts.axis_last) axis_reg <= axis_reg + 1'b1;
            end
            if (cmd.root_init || cmd.div_init) step_reg <= '0;
            if (cmd.root_step || cmd.div_step) step_reg <= step_reg + 5'd1;
            if (cmd.count) begin
                if (cnt_reg >= plrf_pkg::COUNT_LIMIT) sat_reg <= 1'b1;
                else cnt_reg <= cnt_reg + 16'd1;
            end
        end
    end

    assign m_force_x        = out_f_reg[0];
    assign m_force_y        = out_f_reg[1];
    assign m_force_z        = out_f_reg[2];
    assign m_neighbor_count = out_cnt_reg;
    assign m_saturated      = out_sat_reg;

endmodule

FILE: rtl/pairwise_linear_repulsion_force_top.sv
// Sequence: a target item is captured and loaded as the target; a skipped neighbour
// ends after decode or the root check; a contributing neighbour takes 32 root steps,
// then per axis one multiply, a 31-step divide and a gain multiply (shared multiplier).
// Throughput: one item at a time; next item accepted the cycle after one finishes,
// while a finished result may still wait in the output register.
// Reset (aresetn low, synchronous): gain 1.0, target and accumulators cleared.
module pairwise_linear_repulsion_force_top (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration: repulsion gain, unsigned Q16.16
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    // input item
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic [30:0]        s_cutoff_radius,
    input  logic               s_tag_valid,
    input  logic [15:0]        s_unit_tag,
    input  logic               s_last,
    // result item
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [39:0] m_force_x,
    output logic signed [39:0] m_force_y,
    output logic signed [39:0] m_force_z,
    output logic [15:0]        m_neighbor_count,
    output logic               m_saturated
);

    plrf_pkg::cmd_t cmd;
    plrf_pkg::sts_t sts;

    // gain register is always writable
    assign cfg_ready = 1'b1;

    plrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    plrf_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr           (cfg_valid & cfg_ready),
        .cfg_data         (cfg_data),
        .s_op             (s_op),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_cutoff_radius  (s_cutoff_radius),
        .s_tag_valid      (s_tag_valid),
        .s_unit_tag       (s_unit_tag),
        .s_last           (s_last),
        .m_force_x        (m_force_x),
        .m_force_y        (m_force_y),
        .m_force_z        (m_force_z),
        .m_neighbor_count (m_neighbor_count),
        .m_saturated      (m_saturated)
    );

endmodule
